// File: rtl/lasgd_pkg.sv
// ----------------------------------------------------------------------------
// lasgd_pkg
// shared constants and types for the longest arithmetic subsequence core
// ----------------------------------------------------------------------------
package lasgd_pkg;

  // default widths of the value and chain length fields
  localparam int VALUE_BITS_DEF  = 10;
  localparam int LENGTH_BITS_DEF = 12;

  // sequence tag kept beside each table entry
  localparam int EPOCH_BITS = 8;

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIFFERENCE = 3'd0;

  // control states
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } lasgd_state_t;

endpackage

// File: rtl/lasgd_ram.sv
// ----------------------------------------------------------------------------
// lasgd_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lasgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/longest_arith_subseq_given_diff_core.sv
// ----------------------------------------------------------------------------
// longest_arith_subseq_given_diff_core
// streaming longest arithmetic subsequence of a programmable difference
// ----------------------------------------------------------------------------
// Each input item carries one signed value; the core returns one item per
// input item with the chain length ending at that value and the best length
// seen so far in the sequence. The chain table lives in a single ram with a
// registered read: the lookup at value - difference is issued when the item is
// accepted, and the write of the new length happens when the item leaves stage
// 1, with the last write forwarded so that back to back items hitting the same
// entry see it. The core takes one item per clock while out_tready is high and
// no clearing pass runs; a result passes the stage 1 and output registers before
// it appears on out_tvalid. Every ram entry carries a sequence tag, so the end
// of a sequence clears the table at once by moving to a new tag. When the tag
// wraps (every 2^EPOCH_BITS = 256 sequences) and once after reset, the core runs
// a clearing pass over all 2^VALUE_BITS ram entries (1024 by default), during
// which in_tready is low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module longest_arith_subseq_given_diff_core #(
  parameter int VALUE_BITS  = lasgd_pkg::VALUE_BITS_DEF,
  parameter int LENGTH_BITS = lasgd_pkg::LENGTH_BITS_DEF,
  localparam int IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_BITS = ((2 * LENGTH_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [IN_TDATA_BITS-1:0]            in_tdata,   // value
  input  logic                                in_tlast,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_TDATA_BITS-1:0]           out_tdata,  // length_here, best_length
  output logic                                out_tlast,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [lasgd_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [lasgd_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [lasgd_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                                cfg_pready
);

  localparam int DIFF_BITS  = VALUE_BITS + 1;
  localparam int PRED_BITS  = VALUE_BITS + 2;
  localparam int EB         = lasgd_pkg::EPOCH_BITS;
  localparam int WORD_BITS  = EB + LENGTH_BITS;
  localparam int DEPTH      = 1 << VALUE_BITS;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [DIFF_BITS-1:0] diff_r;
  logic                 cfg_wr;
  logic                 cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[lasgd_pkg::CFG_ADDR_BITS-1:2] ==
                       lasgd_pkg::REG_DIFFERENCE[lasgd_pkg::CFG_ADDR_BITS-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? lasgd_pkg::CFG_DATA_BITS'(diff_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r <= '0;
    end else if (cfg_wr && cfg_hit) begin
      diff_r <= cfg_pwdata[DIFF_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // control: clearing pass and sequence tag
  // --------------------------------------------------------------------------
  lasgd_pkg::lasgd_state_t st_r, st_nxt;
  logic [VALUE_BITS-1:0]   sweep_addr_r;
  logic [EB-1:0]           epoch_r;
  logic                    sweep_active;
  logic                    sweep_done;
  logic                    epoch_wrap;

  // stage 1 and output stage signals used by the control
  logic                    s1_valid_r;
  logic                    s1_last_r;
  logic                    s1_adv;
  logic                    out_valid_r;

  assign sweep_done = &sweep_addr_r;
  assign epoch_wrap = s1_adv && s1_last_r && (&epoch_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lasgd_pkg::ST_CLEAR: begin
        if (sweep_done) st_nxt = lasgd_pkg::ST_RUN;
      end
      lasgd_pkg::ST_RUN: begin
        if (epoch_wrap) st_nxt = lasgd_pkg::ST_CLEAR;
      end
      default: st_nxt = lasgd_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    case (st_r)
      lasgd_pkg::ST_CLEAR: sweep_active = 1'b1;
      lasgd_pkg::ST_RUN:   sweep_active = 1'b0;
      default:             sweep_active = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= lasgd_pkg::ST_CLEAR;
      sweep_addr_r <= '0;
      epoch_r      <= '0;
    end else begin
      st_r <= st_nxt;
      // counter wraps to zero at the end of the pass
      if (sweep_active) sweep_addr_r <= sweep_addr_r + 1'b1;
      // a new sequence gets a new tag, stale entries then read as empty
      if (s1_adv && s1_last_r) epoch_r <= epoch_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: accept item, form predecessor, issue the table read
  // --------------------------------------------------------------------------
  logic                  in_acc;
  logic [VALUE_BITS-1:0] in_value;
  logic [PRED_BITS-1:0]  pred;
  logic [2:0]            pred_top;
  logic                  pred_ok;

  assign in_value = in_tdata[VALUE_BITS-1:0];
  assign pred     = {{2{in_value[VALUE_BITS-1]}}, in_value}
                  - {diff_r[DIFF_BITS-1], diff_r};
  // predecessor lies in the value range when its top bits are all sign
  assign pred_top = pred[PRED_BITS-1:VALUE_BITS-1];
  assign pred_ok  = (&pred_top) || !(|pred_top);

  // hold off while clearing, while stage 1 cannot move, and while the last
  // item of a sequence is about to start a clearing pass
  assign in_tready = !sweep_active
                  && !(s1_valid_r && s1_last_r && (&epoch_r))
                  && (!s1_valid_r || !out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // chain table
  // --------------------------------------------------------------------------
  logic                  ram_wr_en;
  logic [VALUE_BITS-1:0] ram_wr_addr;
  logic [WORD_BITS-1:0]  ram_wr_data;
  logic [WORD_BITS-1:0]  ram_rd_data;

  lasgd_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_acc),
    .rd_addr (pred[VALUE_BITS-1:0]),
    .rd_data (ram_rd_data)
  );

  // --------------------------------------------------------------------------
  // stage 1: read data back, extend the chain, write it at the own value
  // --------------------------------------------------------------------------
  logic [VALUE_BITS-1:0]  s1_value_r;
  logic [VALUE_BITS-1:0]  s1_pred_r;
  logic                   s1_pred_ok_r;
  logic                   fwd_valid_r;
  logic [VALUE_BITS-1:0]  fwd_addr_r;
  logic [WORD_BITS-1:0]   fwd_word_r;
  logic [WORD_BITS-1:0]   look_word;
  logic [LENGTH_BITS-1:0] prev_len;
  logic [LENGTH_BITS-1:0] here;
  logic [LENGTH_BITS-1:0] best_r;
  logic [LENGTH_BITS-1:0] best_new;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_tready);

  // the ram read misses a write in the same cycle, so take the last write
  assign look_word = (fwd_valid_r && (fwd_addr_r == s1_pred_r)) ? fwd_word_r
                                                                 : ram_rd_data;
  // an entry of an older sequence counts as empty
  assign prev_len  = (s1_pred_ok_r && (look_word[WORD_BITS-1:LENGTH_BITS] == epoch_r))
                   ? look_word[LENGTH_BITS-1:0] : '0;
  // saturate at the top of the length range
  assign here      = (&prev_len) ? prev_len : prev_len + 1'b1;
  assign best_new  = (here > best_r) ? here : best_r;

  assign ram_wr_en   = sweep_active || s1_adv;
  assign ram_wr_addr = sweep_active ? sweep_addr_r : s1_value_r;
  assign ram_wr_data = sweep_active ? '0 : {epoch_r, here};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      best_r      <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (sweep_active) begin
        fwd_valid_r <= 1'b0;
      end else if (s1_adv) begin
        fwd_valid_r <= 1'b1;
      end
      if (s1_adv) begin
        best_r <= s1_last_r ? '0 : best_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_value_r   <= in_value;
      s1_pred_r    <= pred[VALUE_BITS-1:0];
      s1_pred_ok_r <= pred_ok;
      s1_last_r    <= in_tlast;
    end
    if (s1_adv) begin
      fwd_addr_r <= s1_value_r;
      fwd_word_r <= {epoch_r, here};
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [LENGTH_BITS-1:0] out_here_r;
  logic [LENGTH_BITS-1:0] out_best_r;
  logic                   out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_here_r <= here;
      out_best_r <= best_new;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_BITS'({out_best_r, out_here_r});
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n)
    sweep_active |-> !in_tready
  ) else $error("item accepted during table clearing pass");

  a_best_covers_here: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_best_r >= out_here_r)
  ) else $error("best length below length of this item");

  a_best_cleared_at_end: assert property (
    @(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (best_r == '0)
  ) else $error("running best not cleared after end of sequence");
`endif

endmodule
